/* rtl/core/fldq_pkg.sv */
`default_nettype none
package fldq_pkg;

  localparam int unsigned QUEUE_DEPTH = 256;
  localparam int unsigned LEVELS      = 4;
  localparam int unsigned LEVEL_W     = 2;
  localparam int unsigned SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ADDR_W      = LEVEL_W + SLOT_W;
  localparam int unsigned RAM_DEPTH   = LEVELS << SLOT_W;
  localparam int unsigned JOB_W       = 59;
  localparam int unsigned TDATA_W     = 64;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [FILL_W-1:0]  fill_t;
  typedef logic [JOB_W-1:0]   job_t;

  typedef enum logic {
    OP_ENQUEUE  = 1'b0,
    OP_DISPATCH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_ENQUEUED   = 2'd0,
    STAT_DISPATCHED = 2'd1,
    STAT_EMPTY      = 2'd2,
    STAT_DROPPED    = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  typedef struct packed {
    logic enq;
    logic deq;
  } lvl_cmd_t;

  typedef struct packed {
    logic   full;
    logic   any;
    level_t pick;
    slot_t  tail;
    slot_t  head;
  } lvl_stat_t;

endpackage
`default_nettype wire

/* rtl/core/fldq_ram.sv */
`default_nettype none
module fldq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/fldq_lvl.sv */
`default_nettype none
module fldq_lvl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fldq_pkg::level_t     req_lvl_i,
  input  wire fldq_pkg::lvl_cmd_t   cmd_i,
  output fldq_pkg::lvl_stat_t       stat_o
);
  import fldq_pkg::*;

  slot_t head_q [LEVELS];
  slot_t head_d [LEVELS];
  slot_t tail_q [LEVELS];
  slot_t tail_d [LEVELS];
  fill_t fill_q [LEVELS];
  fill_t fill_d [LEVELS];

  function automatic slot_t next_slot(slot_t s);
    slot_t r;
    if (s == SLOT_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    stat_o.any  = 1'b0;
    stat_o.pick = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (fill_q[l] != '0) begin
        stat_o.any  = 1'b1;
        stat_o.pick = LEVEL_W'(l);
      end
    end
    stat_o.full = (fill_q[req_lvl_i] == FILL_W'(QUEUE_DEPTH));
    stat_o.tail = tail_q[req_lvl_i];
    stat_o.head = head_q[stat_o.pick];
  end

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      head_d[l] = head_q[l];
      tail_d[l] = tail_q[l];
      fill_d[l] = fill_q[l];
    end
    if (cmd_i.enq) begin
      tail_d[req_lvl_i] = next_slot(tail_q[req_lvl_i]);
      fill_d[req_lvl_i] = fill_q[req_lvl_i] + 1'b1;
    end
    if (cmd_i.deq) begin
      head_d[stat_o.pick] = next_slot(head_q[stat_o.pick]);
      fill_d[stat_o.pick] = fill_q[stat_o.pick] - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        fill_q[l] <= '0;
      end
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l] <= head_d[l];
        tail_q[l] <= tail_d[l];
        fill_q[l] <= fill_d[l];
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/four_level_priority_dispatch_queue.sv */
`default_nettype none
// Four strict-priority job queues (level 0 highest) sharing one job memory.
// Each accepted word returns exactly one result word, its kind in m_axis_tuser.
// An enqueue, a drop on a full queue or a dispatch with every queue empty
// loads its result register directly; a dispatch that finds a job first reads
// the job memory, whose read data is registered, and loads the result register
// from that read data in the READ state. One word is in work at a time, and the
// next word is taken as soon as the result register is free or being emptied.
module four_level_priority_dispatch_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // priority_req[1:0], arrival_time[17:2], run_time[33:18], memory_mb[44:34],
  // printer_count[48:45], scanner_count[52:49], modem_count[56:53],
  // disc_count[60:57], zero fill above
  input  wire logic [fldq_pkg::TDATA_W-1:0]  s_axis_tdata,
  // op[0]
  input  wire logic                          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // served_level[1:0], out_arrival_time[17:2], out_run_time[33:18],
  // out_memory_mb[44:34], out_printers[48:45], out_scanners[52:49],
  // out_modems[56:53], out_discs[60:57], zero fill above
  output logic      [fldq_pkg::TDATA_W-1:0]  m_axis_tdata,
  // status[1:0]
  output logic      [1:0]                    m_axis_tuser
);
  import fldq_pkg::*;

  state_e    state_q, state_d;
  lvl_cmd_t  cmd;
  lvl_stat_t stat;
  level_t    req_lvl;
  job_t      in_job;
  job_t      rdata;
  logic      in_acc;
  logic      is_disp;
  logic      ram_we;
  logic      ram_re;
  logic      out_free;
  logic      load_now;
  logic      load_read;
  level_t    rd_lvl_q;
  logic      out_valid_q;
  status_e   out_status_q, out_status_d;
  level_t    out_level_q;
  job_t      out_job_q;

  assign req_lvl  = s_axis_tdata[LEVEL_W-1:0];
  assign in_job   = s_axis_tdata[LEVEL_W +: JOB_W];
  assign is_disp  = (op_e'(s_axis_tuser) == OP_DISPATCH);
  assign out_free = !out_valid_q || m_axis_tready;
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  fldq_lvl u_lvl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_lvl_i (req_lvl),
    .cmd_i     (cmd),
    .stat_o    (stat)
  );

  fldq_ram #(
    .WIDTH (JOB_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({req_lvl, stat.tail}),
    .wdata_i (in_job),
    .re_i    (ram_re),
    .raddr_i ({stat.pick, stat.head}),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_disp && stat.any) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    cmd           = '0;
    load_now      = 1'b0;
    load_read     = 1'b0;
    out_status_d  = STAT_ENQUEUED;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = out_free;
        if (in_acc) begin
          if (is_disp) begin
            if (stat.any) begin
              ram_re  = 1'b1;
              cmd.deq = 1'b1;
            end else begin
              load_now     = 1'b1;
              out_status_d = STAT_EMPTY;
            end
          end else begin
            load_now = 1'b1;
            if (stat.full) begin
              out_status_d = STAT_DROPPED;
            end else begin
              ram_we       = 1'b1;
              cmd.enq      = 1'b1;
              out_status_d = STAT_ENQUEUED;
            end
          end
        end
      end
      ST_READ: begin
        load_read    = 1'b1;
        out_status_d = STAT_DISPATCHED;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_now || load_read) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      rd_lvl_q <= stat.pick;
    end
    if (load_now) begin
      out_status_q <= out_status_d;
      out_level_q  <= '0;
      out_job_q    <= '0;
    end else if (load_read) begin
      out_status_q <= out_status_d;
      out_level_q  <= rd_lvl_q;
      out_job_q    <= rdata;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{(TDATA_W - JOB_W - LEVEL_W){1'b0}}, out_job_q, out_level_q};

endmodule
`default_nettype wire

/* test/four_level_priority_dispatch_queue_test.sv */
`default_nettype none
module four_level_priority_dispatch_queue_test;
  import fldq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 400;

  typedef struct packed {
    logic [3:0]  discs;
    logic [3:0]  modems;
    logic [3:0]  scanners;
    logic [3:0]  printers;
    logic [10:0] memory_mb;
    logic [15:0] run_time;
    logic [15:0] arrival_time;
  } job_fields_t;

  typedef struct packed {
    status_e     status;
    level_t      level;
    job_fields_t job;
  } dispatch_result_t;

  class dispatch_scoreboard;
    job_fields_t      level_jobs[LEVELS][$];
    dispatch_result_t pending_results[$];
    int               errors;

    function void note_word(op_e op, logic [TDATA_W-1:0] data);
      level_t           lvl;
      job_fields_t      job;
      dispatch_result_t res;
      bit               found;
      lvl = data[1:0];
      job = data[60:2];
      res = '0;
      found = 1'b0;
      if (op == OP_ENQUEUE) begin
        if (level_jobs[lvl].size() >= QUEUE_DEPTH) begin
          res.status = STAT_DROPPED;
        end else begin
          level_jobs[lvl].push_back(job);
          res.status = STAT_ENQUEUED;
        end
      end else begin
        res.status = STAT_EMPTY;
        for (int l = 0; l < LEVELS; l++) begin
          if (!found && level_jobs[l].size() != 0) begin
            found = 1'b1;
            res.status = STAT_DISPATCHED;
            res.level = level_t'(l);
            res.job = level_jobs[l].pop_front();
          end
        end
      end
      pending_results.push_back(res);
    endfunction

    function void compare_field(string name, longint unsigned exp_val,
                                longint unsigned act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s expected %0h got %0h", $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_word(logic [TDATA_W-1:0] data, logic [1:0] kind);
      dispatch_result_t res;
      job_fields_t      got;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none got tuser %0h tdata %h",
                 $time, kind, data);
        errors++;
        return;
      end
      res = pending_results.pop_front();
      got = data[60:2];
      compare_field("status", res.status, kind);
      compare_field("served_level", res.level, data[1:0]);
      compare_field("out_arrival_time", res.job.arrival_time, got.arrival_time);
      compare_field("out_run_time", res.job.run_time, got.run_time);
      compare_field("out_memory_mb", res.job.memory_mb, got.memory_mb);
      compare_field("out_printers", res.job.printers, got.printers);
      compare_field("out_scanners", res.job.scanners, got.scanners);
      compare_field("out_modems", res.job.modems, got.modems);
      compare_field("out_discs", res.job.discs, got.discs);
      compare_field("tdata fill", 0, data[TDATA_W-1:61]);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [1:0]         m_axis_tuser;

  dispatch_scoreboard sb = new;
  int unsigned        cycles;
  int unsigned        tx_count;
  int unsigned        rx_count;
  bit                 tx_burst;
  bit                 rx_burst;
  bit                 long_hold_done;

  four_level_priority_dispatch_queue dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_word(op_e'(s_axis_tuser), s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_word(m_axis_tdata, m_axis_tuser);
      end
    end
  end

  function automatic job_fields_t random_job();
    job_fields_t job;
    job.arrival_time = 16'($urandom);
    job.run_time     = 16'($urandom);
    job.memory_mb    = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(1025, 2047))
                                                   : 11'($urandom_range(0, 1024));
    job.printers     = 4'($urandom_range(0, 15));
    job.scanners     = 4'($urandom_range(0, 15));
    job.modems       = 4'($urandom_range(0, 15));
    job.discs        = 4'($urandom_range(0, 15));
    return job;
  endfunction

  task automatic send_word(op_e op, level_t lvl, job_fields_t job);
    int unsigned gap;
    if (tx_count % 64 == 0) begin
      tx_burst = ($urandom_range(0, 2) == 0);
    end
    tx_count++;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, job, lvl};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic run_mix(int unsigned count, int unsigned dispatch_pct);
    op_e op;
    for (int unsigned i = 0; i < count; i++) begin
      op = ($urandom_range(0, 99) < dispatch_pct) ? OP_DISPATCH : OP_ENQUEUE;
      send_word(op, level_t'($urandom_range(0, 3)), random_job());
    end
  endtask

  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_count % 50 == 0) begin
        rx_burst = ($urandom_range(0, 2) == 0);
      end
      stall = rx_burst ? 0 : $urandom_range(0, 16);
      if (rx_count >= 200 && !long_hold_done) begin
        long_hold_done = 1'b1;
        stall = LONG_HOLD;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      rx_count++;
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    job_fields_t zero_job;
    job_fields_t ones_job;
    job_fields_t alt_a;
    job_fields_t alt_b;
    level_t      full_level;
    zero_job = '0;
    ones_job = '1;
    alt_a = '{discs: 4'h5, modems: 4'hA, scanners: 4'h5, printers: 4'hA,
              memory_mb: 11'd1024, run_time: 16'h5555, arrival_time: 16'hAAAA};
    alt_b = '{discs: 4'hA, modems: 4'h5, scanners: 4'hA, printers: 4'h5,
              memory_mb: 11'h3FF, run_time: 16'hAAAA, arrival_time: 16'h5555};
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= OP_ENQUEUE;
    s_axis_tdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(OP_DISPATCH, 2'd0, zero_job);
    send_word(OP_ENQUEUE, 2'd3, zero_job);
    send_word(OP_ENQUEUE, 2'd2, ones_job);
    send_word(OP_ENQUEUE, 2'd1, alt_a);
    send_word(OP_ENQUEUE, 2'd0, alt_b);
    send_word(OP_ENQUEUE, 2'd3, ones_job);
    repeat (6) send_word(OP_DISPATCH, level_t'($urandom_range(0, 3)), random_job());
    send_word(OP_ENQUEUE, 2'd3, random_job());
    send_word(OP_ENQUEUE, 2'd1, random_job());
    send_word(OP_DISPATCH, 2'd0, zero_job);
    send_word(OP_ENQUEUE, 2'd0, random_job());
    send_word(OP_DISPATCH, 2'd3, ones_job);
    send_word(OP_DISPATCH, 2'd0, zero_job);
    send_word(OP_DISPATCH, 2'd0, zero_job);

    run_mix(600, 45);

    full_level = level_t'($urandom_range(0, 3));
    for (int unsigned i = 0; i < QUEUE_DEPTH + 6; i++) begin
      send_word(OP_ENQUEUE, full_level, random_job());
    end
    for (int unsigned i = 0; i < 270; i++) begin
      send_word(OP_DISPATCH, level_t'($urandom_range(0, 3)), random_job());
    end

    run_mix(300, 55);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
rtl/core/fldq_pkg.sv
rtl/core/fldq_ram.sv
rtl/core/fldq_lvl.sv
rtl/core/four_level_priority_dispatch_queue.sv
test/four_level_priority_dispatch_queue_test.sv
